/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the slot table block.
// Depends on nothing; pulled in with `include by files that check properties.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/itrl_pkg.sv */
// Types, codes and sizes for the reference-counted slot table.
// Used by itrl_cell, itrl_chain and inode_table_refcount_lookup_unit.
package itrl_pkg;

    localparam int TABLE_SLOTS   = 64;
    localparam int ROOT_NUMBER   = 2;
    localparam int MAX_REDIRECTS = 8;

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int HOP_W  = $clog2(MAX_REDIRECTS + 1);
    localparam int SLOT_W = 6;
    localparam int KEY_W  = 16;
    localparam int RC_W   = 8;
    localparam logic [RC_W-1:0] RC_MAX = '1;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_UNLOCK = 2'd2,
        OP_MOUNT  = 2'd3
    } op_e;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_NEW      = 3'd1,
        ST_LOCKED   = 3'd2,
        ST_FULL     = 3'd3,
        ST_REDIRECT = 3'd4,
        ST_DONE     = 3'd5
    } status_e;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_TAKE,
        CMD_ALLOC,
        CMD_PUT,
        CMD_UNLOCK,
        CMD_MOUNT
    } cmd_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_e;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KEY_W-1:0]  device;
        logic [KEY_W-1:0]  number;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_out;
        logic [KEY_W-1:0]  device_out;
        logic [KEY_W-1:0]  number_out;
        logic              last_reference;
    } rsp_t;

    // Key broadcast to every cell during a search pass.
    typedef struct packed {
        logic [KEY_W-1:0] device;
        logic [KEY_W-1:0] number;
        logic [IDX_W-1:0] idx;
    } key_t;

    // Update broadcast to every cell; only the addressed cell acts on it.
    typedef struct packed {
        cmd_e             kind;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] device;
        logic [KEY_W-1:0] number;
    } cmd_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] hit_idx;
        logic             hit_locked;
        logic             hit_mounted;
        logic [KEY_W-1:0] hit_target;
        logic             have_free;
        logic [IDX_W-1:0] free_idx;
        logic             sel_last;
    } token_t;

endpackage

/* sv/itrl_cell.sv */
// One table slot: holds its key, count and flags, and advances the search token.
// Depends on itrl_pkg.
module itrl_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [itrl_pkg::IDX_W-1:0]  index,
    input  itrl_pkg::key_t              key,
    input  itrl_pkg::cmd_t              cmd,
    input  itrl_pkg::token_t            tok_in,
    output itrl_pkg::token_t            tok_out
);

    logic [itrl_pkg::KEY_W-1:0] dev_reg, dev_next;
    logic [itrl_pkg::KEY_W-1:0] num_reg, num_next;
    logic [itrl_pkg::RC_W-1:0]  rc_reg, rc_next;
    logic                       locked_reg, locked_next;
    logic                       mounted_reg, mounted_next;
    logic [itrl_pkg::KEY_W-1:0] target_reg, target_next;
    itrl_pkg::token_t           tok_reg, tok_next;

    logic match;
    logic addressed;

    assign match     = (dev_reg == key.device) && (num_reg == key.number);
    assign addressed = (cmd.idx == index);

    // Search: first match wins, otherwise note the first free slot.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found)
        begin
            if (match)
            begin
                tok_next.found       = 1'b1;
                tok_next.hit_idx     = index;
                tok_next.hit_locked  = locked_reg;
                tok_next.hit_mounted = mounted_reg;
                tok_next.hit_target  = target_reg;
            end
            else if (!tok_in.have_free && (rc_reg == '0))
            begin
                tok_next.have_free = 1'b1;
                tok_next.free_idx  = index;
            end
        end
        if (tok_in.valid && (index == key.idx))
        begin
            tok_next.sel_last = (rc_reg == itrl_pkg::RC_W'(1));
        end
    end

    // Slot update.
    always_comb
    begin
        dev_next     = dev_reg;
        num_next     = num_reg;
        rc_next      = rc_reg;
        locked_next  = locked_reg;
        mounted_next = mounted_reg;
        target_next  = target_reg;
        if (addressed)
        begin
            case (cmd.kind)
                itrl_pkg::CMD_TAKE:
                begin
                    if (rc_reg != itrl_pkg::RC_MAX)
                    begin
                        rc_next = rc_reg + itrl_pkg::RC_W'(1);
                    end
                    locked_next = 1'b1;
                end
                itrl_pkg::CMD_ALLOC:
                begin
                    dev_next     = cmd.device;
                    num_next     = cmd.number;
                    rc_next      = itrl_pkg::RC_W'(1);
                    locked_next  = 1'b1;
                    mounted_next = 1'b0;
                    target_next  = '0;
                end
                itrl_pkg::CMD_PUT:
                begin
                    if (rc_reg != '0)
                    begin
                        // Drop the key and flags on the final reference.
                        if (rc_reg == itrl_pkg::RC_W'(1))
                        begin
                            dev_next     = '0;
                            num_next     = '0;
                            mounted_next = 1'b0;
                            target_next  = '0;
                        end
                        rc_next     = rc_reg - itrl_pkg::RC_W'(1);
                        locked_next = 1'b0;
                    end
                end
                itrl_pkg::CMD_UNLOCK:
                begin
                    locked_next = 1'b0;
                end
                itrl_pkg::CMD_MOUNT:
                begin
                    mounted_next = 1'b1;
                    target_next  = cmd.device;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg     <= '0;
            num_reg     <= '0;
            rc_reg      <= '0;
            locked_reg  <= 1'b0;
            mounted_reg <= 1'b0;
            target_reg  <= '0;
            tok_reg     <= '0;
        end
        else
        begin
            dev_reg     <= dev_next;
            num_reg     <= num_next;
            rc_reg      <= rc_next;
            locked_reg  <= locked_next;
            mounted_reg <= mounted_next;
            target_reg  <= target_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* sv/itrl_chain.sv */
// Row of slot cells; a search token enters at cell 0 and leaves after the last.
// Depends on itrl_pkg and itrl_cell.
module itrl_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              launch,
    input  itrl_pkg::key_t    key,
    input  itrl_pkg::cmd_t    cmd,
    output itrl_pkg::token_t  tok_out
);

    itrl_pkg::token_t link [itrl_pkg::TABLE_SLOTS+1];
    itrl_pkg::token_t head;

    always_comb
    begin
        head       = '0;
        head.valid = launch;
    end

    assign link[0] = head;

    for (genvar i = 0; i < itrl_pkg::TABLE_SLOTS; i++)
    begin : g_cell
        itrl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   (itrl_pkg::IDX_W'(i)),
            .key     (key),
            .cmd     (cmd),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

    assign tok_out = link[itrl_pkg::TABLE_SLOTS];

endmodule

/* sv/inode_table_refcount_lookup_unit.sv */
// Reference-counted slot table of cached file identifiers, keyed by (device, number).
// Depends on itrl_pkg, itrl_chain, itrl_cell and assert_macros.svh.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one request: get by key, put,
//   unlock or mount on a slot. rsp channel (rsp_valid/rsp_ready/rsp) returns
//   exactly one response per request, in order.
//   Every request makes one pass of a search token down a row of TABLE_SLOTS
//   cells, one cell per cycle; that pass sets the timing. The token is launched
//   from a register; the result of the last pass is registered in the finish
//   state and the response in the output register. Each mount redirection of
//   a get adds another pass, up to MAX_REDIRECTS of them.
//   One request is worked on at a time. The response sits in an output
//   register, so the next request is accepted while it waits; if the receiver
//   still stalls when that request finishes, the unit holds in its finish
//   state and applies no slot update until the earlier response is taken.
//   Reset clears every slot (key, count, flags, mount target) to zero at
//   once, drops any search in flight and empties the output register.
`include "assert_macros.svh"

module inode_table_refcount_lookup_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  itrl_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output itrl_pkg::rsp_t  rsp
);

    itrl_pkg::state_e           state_reg, state_next;
    itrl_pkg::req_t             req_reg, req_next;
    logic [itrl_pkg::KEY_W-1:0] key_dev_reg, key_dev_next;
    logic [itrl_pkg::KEY_W-1:0] key_num_reg, key_num_next;
    logic [itrl_pkg::HOP_W-1:0] hops_reg, hops_next;
    logic                       launch_reg, launch_next;
    itrl_pkg::token_t           tok_reg, tok_next;
    itrl_pkg::rsp_t             rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    itrl_pkg::key_t   key;
    itrl_pkg::cmd_t   cmd;
    itrl_pkg::token_t chain_tok;
    logic             in_range;
    logic             out_free;
    logic             redirect;

    // Broadcast key: current search key plus the addressed slot for put.
    assign key.device = key_dev_reg;
    assign key.number = key_num_reg;
    assign key.idx    = itrl_pkg::IDX_W'(req_reg.slot);

    itrl_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (launch_reg),
        .key     (key),
        .cmd     (cmd),
        .tok_out (chain_tok)
    );

    assign in_range = (32'(req_reg.slot) < 32'(itrl_pkg::TABLE_SLOTS));
    assign out_free = !rsp_valid_reg || rsp_ready;

    // For a get, a hit on a mounted, unlocked slot restarts the search on the
    // mounted device's root, unless the hop budget is used up.
    assign redirect = (req_reg.operation == itrl_pkg::OP_GET) && chain_tok.found
                      && !chain_tok.hit_locked && chain_tok.hit_mounted
                      && (hops_reg != itrl_pkg::HOP_W'(itrl_pkg::MAX_REDIRECTS));

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        key_dev_next   = key_dev_reg;
        key_num_next   = key_num_reg;
        hops_next      = hops_reg;
        launch_next    = 1'b0;
        tok_next       = tok_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.kind       = itrl_pkg::CMD_NONE;

        case (state_reg)
            itrl_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next     = req;
                    key_dev_next = req.device;
                    key_num_next = req.number;
                    hops_next    = '0;
                    launch_next  = 1'b1;
                    state_next   = itrl_pkg::S_SEARCH;
                end
            end

            itrl_pkg::S_SEARCH:
            begin
                if (chain_tok.valid)
                begin
                    if (redirect)
                    begin
                        key_dev_next = chain_tok.hit_target;
                        key_num_next = itrl_pkg::KEY_W'(itrl_pkg::ROOT_NUMBER);
                        hops_next    = hops_reg + itrl_pkg::HOP_W'(1);
                        launch_next  = 1'b1;
                    end
                    else
                    begin
                        tok_next   = chain_tok;
                        state_next = itrl_pkg::S_FINISH;
                    end
                end
            end

            itrl_pkg::S_FINISH:
            begin
                // Hold until the output register is free, then apply the
                // update and post the response in the same cycle.
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = itrl_pkg::S_IDLE;
                    rsp_next       = '0;
                    cmd.idx        = itrl_pkg::IDX_W'(req_reg.slot);
                    cmd.device     = req_reg.device;
                    if (req_reg.operation == itrl_pkg::OP_GET)
                    begin
                        rsp_next.device_out = key_dev_reg;
                        rsp_next.number_out = key_num_reg;
                        cmd.device          = key_dev_reg;
                        cmd.number          = key_num_reg;
                        if (tok_reg.found)
                        begin
                            rsp_next.slot_out = itrl_pkg::SLOT_W'(tok_reg.hit_idx);
                            cmd.idx           = tok_reg.hit_idx;
                            if (tok_reg.hit_locked)
                            begin
                                rsp_next.status = itrl_pkg::ST_LOCKED;
                            end
                            else if (tok_reg.hit_mounted)
                            begin
                                rsp_next.status = itrl_pkg::ST_REDIRECT;
                            end
                            else
                            begin
                                rsp_next.status = itrl_pkg::ST_HIT;
                                cmd.kind        = itrl_pkg::CMD_TAKE;
                            end
                        end
                        else if (tok_reg.have_free)
                        begin
                            rsp_next.status   = itrl_pkg::ST_NEW;
                            rsp_next.slot_out = itrl_pkg::SLOT_W'(tok_reg.free_idx);
                            cmd.idx           = tok_reg.free_idx;
                            cmd.kind          = itrl_pkg::CMD_ALLOC;
                        end
                        else
                        begin
                            rsp_next.status = itrl_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        rsp_next.status   = itrl_pkg::ST_DONE;
                        rsp_next.slot_out = req_reg.slot;
                        if (in_range)
                        begin
                            case (req_reg.operation)
                                itrl_pkg::OP_PUT:
                                begin
                                    cmd.kind                = itrl_pkg::CMD_PUT;
                                    rsp_next.last_reference = tok_reg.sel_last;
                                end
                                itrl_pkg::OP_UNLOCK:
                                begin
                                    cmd.kind = itrl_pkg::CMD_UNLOCK;
                                end
                                itrl_pkg::OP_MOUNT:
                                begin
                                    cmd.kind = itrl_pkg::CMD_MOUNT;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
            end

            default:
            begin
                state_next = itrl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itrl_pkg::S_IDLE;
            launch_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            hops_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
            hops_reg      <= hops_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        key_dev_reg <= key_dev_next;
        key_num_reg <= key_num_next;
        tok_reg     <= tok_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A token leaves the row only while a search is waiting for it.
    `ASSERT_SAME(a_token_in_search, clk, rst_n, chain_tok.valid, state_reg == itrl_pkg::S_SEARCH, "search token left the row outside a search")
    // A launched token always belongs to a search pass.
    `ASSERT_SAME(a_launch_in_search, clk, rst_n, launch_reg, state_reg == itrl_pkg::S_SEARCH, "token launched outside a search")
    // The hop count never passes the redirect budget.
    `ASSERT_SAME(a_hops_bounded, clk, rst_n, state_reg == itrl_pkg::S_SEARCH, hops_reg <= itrl_pkg::HOP_W'(itrl_pkg::MAX_REDIRECTS), "redirect count above limit")
    // Finishing with a free output register posts a response next cycle.
    `ASSERT_NEXT(a_finish_posts, clk, rst_n, (state_reg == itrl_pkg::S_FINISH) && !rsp_valid_reg, rsp_valid_reg && (state_reg == itrl_pkg::S_IDLE), "finished request did not post a response")

endmodule

/* tb/itrl_table_checker.sv */
// Response checker for the slot table: tracks table contents from accepted requests,
// predicts each response and compares it with what the unit returns.
// Depends on itrl_pkg.
module itrl_table_checker
    import itrl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [KEY_W-1:0] slot_dev   [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_num   [TABLE_SLOTS];
    logic [RC_W-1:0]  use_count  [TABLE_SLOTS];
    logic             is_locked  [TABLE_SLOTS];
    logic             is_mounted [TABLE_SLOTS];
    logic [KEY_W-1:0] mount_dev  [TABLE_SLOTS];

    rsp_t pending_replies [$];

    // Apply one request to the table copy and return the response it should produce.
    function automatic rsp_t apply_request(req_t r);
        rsp_t             res;
        logic [KEY_W-1:0] dev;
        logic [KEY_W-1:0] num;
        int               hops;
        int               free_idx;
        int               s;
        bit               have_free;
        bit               redirected;
        res = '0;
        s   = int'(r.slot);
        if (r.operation != OP_GET)
        begin
            res.status   = ST_DONE;
            res.slot_out = r.slot;
            if (s < TABLE_SLOTS)
            begin
                case (r.operation)
                    OP_PUT:
                    begin
                        if (use_count[s] != '0)
                        begin
                            if (use_count[s] == RC_W'(1))
                            begin
                                res.last_reference = 1'b1;
                                slot_dev[s]   = '0;
                                slot_num[s]   = '0;
                                is_mounted[s] = 1'b0;
                                mount_dev[s]  = '0;
                            end
                            use_count[s] = use_count[s] - RC_W'(1);
                            is_locked[s] = 1'b0;
                        end
                    end
                    OP_UNLOCK:
                        is_locked[s] = 1'b0;
                    default:
                    begin
                        is_mounted[s] = 1'b1;
                        mount_dev[s]  = r.device;
                    end
                endcase
            end
            return res;
        end

        dev  = r.device;
        num  = r.number;
        hops = 0;
        do
        begin
            redirected = 1'b0;
            have_free  = 1'b0;
            free_idx   = 0;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (slot_dev[i] == dev && slot_num[i] == num)
                begin
                    res.slot_out   = SLOT_W'(i);
                    res.device_out = dev;
                    res.number_out = num;
                    if (is_locked[i])
                    begin
                        res.status = ST_LOCKED;
                        return res;
                    end
                    if (is_mounted[i])
                    begin
                        if (hops >= MAX_REDIRECTS)
                        begin
                            res.status = ST_REDIRECT;
                            return res;
                        end
                        hops++;
                        dev        = mount_dev[i];
                        num        = KEY_W'(ROOT_NUMBER);
                        redirected = 1'b1;
                        break;
                    end
                    if (use_count[i] != RC_MAX)
                        use_count[i] = use_count[i] + RC_W'(1);
                    is_locked[i] = 1'b1;
                    res.status   = ST_HIT;
                    return res;
                end
                if (!have_free && use_count[i] == '0)
                begin
                    have_free = 1'b1;
                    free_idx  = i;
                end
            end
        end
        while (redirected);

        res.device_out = dev;
        res.number_out = num;
        if (!have_free)
        begin
            res.status   = ST_FULL;
            res.slot_out = '0;
            return res;
        end
        slot_dev[free_idx]   = dev;
        slot_num[free_idx]   = num;
        use_count[free_idx]  = RC_W'(1);
        is_locked[free_idx]  = 1'b1;
        is_mounted[free_idx] = 1'b0;
        mount_dev[free_idx]  = '0;
        res.status   = ST_NEW;
        res.slot_out = SLOT_W'(free_idx);
        return res;
    endfunction

    function automatic int field_differs(string name, logic [KEY_W-1:0] want,
                                         logic [KEY_W-1:0] got);
        if (got === want)
            return 0;
        $display("%0t: rsp.%s mismatch: expected %h, got %h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_t want;
        int   bad;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                slot_dev[i]   = '0;
                slot_num[i]   = '0;
                use_count[i]  = '0;
                is_locked[i]  = 1'b0;
                is_mounted[i] = 1'b0;
                mount_dev[i]  = '0;
            end
            pending_replies.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Retire the response first: it always belongs to an earlier request.
            if (rsp_valid && rsp_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: response with nothing expected: status %h slot %h key %h/%h",
                             $time, rsp.status, rsp.slot_out, rsp.device_out, rsp.number_out);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    bad  = field_differs("status", KEY_W'(want.status), KEY_W'(rsp.status))
                         + field_differs("slot_out", KEY_W'(want.slot_out),
                                         KEY_W'(rsp.slot_out))
                         + field_differs("device_out", want.device_out, rsp.device_out)
                         + field_differs("number_out", want.number_out, rsp.number_out)
                         + field_differs("last_reference", KEY_W'(want.last_reference),
                                         KEY_W'(rsp.last_reference));
                    mismatches <= mismatches + bad;
                end
            end
            if (req_valid && req_ready)
                pending_replies.push_back(apply_request(req));
            outstanding <= pending_replies.size();
        end
    end

endmodule

/* tb/inode_table_refcount_lookup_unit_tb.sv */
// Top of the slot table testbench: clock, reset, request stimulus and response stalls.
// Depends on itrl_pkg, itrl_table_checker and the unit inode_table_refcount_lookup_unit.
module inode_table_refcount_lookup_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import itrl_pkg::*;

    // Worst case is roughly 460 requests, each a fully redirected get, plus gaps
    // and stalls; this bound sits several times above that.
    localparam int unsigned RUN_LIMIT_NS = 10_000_000;
    localparam int          DRAIN_CYCLES = 150;

    // Keys that random gets draw from, so that hits, locks and redirects recur.
    localparam logic [0:4][KEY_W-1:0] DEV_POOL =
        {16'h0000, 16'h0001, 16'h5A5A, 16'hA5A5, 16'hFFFF};
    localparam logic [0:3][KEY_W-1:0] NUM_POOL =
        {16'h0002, 16'h0001, 16'h8000, 16'hFFFF};

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;
    bit   steady_tail;

    always #1 clk = ~clk;

    inode_table_refcount_lookup_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    itrl_table_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic req_t make_req(op_e op, logic [KEY_W-1:0] dev,
                                      logic [KEY_W-1:0] num, logic [SLOT_W-1:0] slot);
        req_t r;
        r.operation = op;
        r.device    = dev;
        r.number    = num;
        r.slot      = slot;
        return r;
    endfunction

    // Mostly gets on a small key pool and slot actions on the low slots, where
    // allocation lands; the rest is random keys and slots across the full range.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r.device = KEY_W'($urandom());
        r.number = KEY_W'($urandom());
        r.slot   = ($urandom_range(0, 6) == 0) ? SLOT_W'($urandom_range(0, TABLE_SLOTS - 1))
                                                : SLOT_W'($urandom_range(0, 11));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.operation = OP_GET;
            r.device    = DEV_POOL[$urandom_range(0, 4)];
            r.number    = NUM_POOL[$urandom_range(0, 3)];
        end
        else if (pick < 46)
            r.operation = OP_GET;
        else if (pick < 71)
            r.operation = OP_PUT;
        else if (pick < 91)
            r.operation = OP_UNLOCK;
        else
        begin
            r.operation = OP_MOUNT;
            r.device    = DEV_POOL[$urandom_range(0, 4)];
        end
        return r;
    endfunction

    // Present one request from a falling edge and hold it until the unit takes it,
    // then sometimes drop valid for a short burst. Returns on a falling edge.
    task automatic issue(input req_t r);
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
        if (!steady_tail && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // Response side: ready for a random stretch, then stall for a random burst;
    // in the final stretch of the run hold ready high.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(negedge clk);
            if (!steady_tail)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        steady_tail = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening. A freshly reset table holds key (0, 0) everywhere with
        // count zero, so a get of that key hits slot 0 rather than allocating.
        issue(make_req(OP_GET,    16'h0000, 16'h0000, 6'd0));
        // Allocate at the extreme key, bounce off its lock, then hit it once unlocked.
        issue(make_req(OP_GET,    16'hFFFF, 16'hFFFF, 6'd63));
        issue(make_req(OP_GET,    16'hFFFF, 16'hFFFF, 6'd0));
        issue(make_req(OP_UNLOCK, 16'hFFFF, 16'hFFFF, 6'd1));
        issue(make_req(OP_GET,    16'hFFFF, 16'hFFFF, 6'd63));
        // Drop both references: the second one is the last and clears the slot;
        // a third put finds a zero count and is ignored.
        issue(make_req(OP_PUT,    16'h0000, 16'h0000, 6'd1));
        issue(make_req(OP_PUT,    16'hFFFF, 16'hFFFF, 6'd1));
        issue(make_req(OP_PUT,    16'h0000, 16'h0000, 6'd1));
        // Mount a slot on its own device: every search lands back on it, so the
        // redirect limit trips.
        issue(make_req(OP_GET,    16'h1234, 16'h0002, 6'd0));
        issue(make_req(OP_UNLOCK, 16'h0000, 16'h0000, 6'd1));
        issue(make_req(OP_MOUNT,  16'h1234, 16'h0000, 6'd1));
        issue(make_req(OP_GET,    16'h1234, 16'h0002, 6'd0));
        // Retarget the mount at a real root entry: one redirection, then a hit.
        issue(make_req(OP_GET,    16'hABCD, 16'h0002, 6'd0));
        issue(make_req(OP_UNLOCK, 16'h0000, 16'h0000, 6'd2));
        issue(make_req(OP_MOUNT,  16'hABCD, 16'hFFFF, 6'd1));
        issue(make_req(OP_GET,    16'h1234, 16'h0002, 6'd63));
        // Slot actions on the top slot while it is empty.
        issue(make_req(OP_PUT,    16'hFFFF, 16'hFFFF, 6'd63));
        issue(make_req(OP_UNLOCK, 16'hFFFF, 16'hFFFF, 6'd63));
        issue(make_req(OP_MOUNT,  16'h0000, 16'hFFFF, 6'd63));
        // Slot 0 still locked from the first get; release it, then the freed
        // zero-count slot is hit again.
        issue(make_req(OP_GET,    16'h0000, 16'h0000, 6'd0));
        issue(make_req(OP_PUT,    16'h0000, 16'h0000, 6'd0));
        issue(make_req(OP_GET,    16'h0000, 16'h0000, 6'd0));

        // Fill every free slot with distinct keys until the table reports full.
        for (int i = 0; i < TABLE_SLOTS + 2; i++)
            issue(make_req(OP_GET, KEY_W'(16'h5000 + i), KEY_W'(16'hFFFF - i), SLOT_W'(i)));
        // Drain every slot back to zero; counts are at most two here.
        for (int i = 0; i < 2 * TABLE_SLOTS; i++)
            issue(make_req(OP_PUT, 16'h0000, 16'h0000, SLOT_W'(i % TABLE_SLOTS)));

        // Random traffic; the last stretch runs with no idling on either side.
        for (int i = 0; i < 240; i++)
        begin
            if (i == 200)
                steady_tail = 1'b1;
            issue(random_request());
        end
        req_valid <= 1'b0;

        // Wait for every expected response, then watch a while for strays.
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("inode_table_refcount_lookup_unit regression: pass");
        else
            $display("inode_table_refcount_lookup_unit regression: fail");
        $finish;
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("inode_table_refcount_lookup_unit regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/itrl_pkg.sv
sv/itrl_cell.sv
sv/itrl_chain.sv
sv/inode_table_refcount_lookup_unit.sv
tb/itrl_table_checker.sv
tb/inode_table_refcount_lookup_unit_tb.sv
